// ===== sv/tick_calendar_clock_macros.svh =====
// assertion macros for the tick calendar clock
// used by tick_calendar_clock.sv; expects clk and rst_n in scope
`ifndef TICK_CALENDAR_CLOCK_MACROS_SVH
`define TICK_CALENDAR_CLOCK_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TCC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick calendar clock check failed");
// next-cycle implication
`define TCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick calendar clock check failed");
`else
`define TCC_ASSERT_IMPL(lbl, ante, cons)
`define TCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/tcc_pkg.sv =====
// package for the tick calendar clock: op codes, calendar constants, month table
// no dependencies
`default_nettype none

package tcc_pkg;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_READ   = 2'd1,
        OP_REBASE = 2'd2
    } op_t;

    localparam int unsigned TICK_HZ_DEF = 1193182;

    // divisor and remainder width of the serial divider (tick rate up to 1e9)
    localparam int unsigned DIV_W  = 30;
    localparam int unsigned CNT_W  = 7;

    localparam int unsigned CS_PER_DAY  = 8640000;
    localparam int unsigned CS_PER_HOUR = 360000;
    localparam int unsigned CS_PER_MIN  = 6000;
    localparam int unsigned CS_PER_SEC  = 100;
    localparam int unsigned EPOCH_DAYS  = 3652;
    localparam int unsigned SHIFT_DAYS  = 719468;
    localparam int unsigned ERA_DAYS    = 146097;
    // shift plus epoch offset, subtracted when a date becomes a day count
    localparam int unsigned SET_OFFSET  = 723120;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

endpackage

`default_nettype wire

// ===== sv/tick_calendar_clock.sv =====
// tick calendar clock: base time keeping, date checking and calendar conversion
// depends on tcc_pkg and tick_calendar_clock_macros.svh
//
// usage
//   command channel: drive op, now_tick and the set_* fields with start high while
//   busy is low; the word is taken at that edge. op set checks the date and time
//   and stores a new base, op read returns date, weekday and time, op rebase folds
//   the elapsed time into the base and zeroes the base tick.
//   result channel: done is high for exactly one cycle with the result word on
//   accepted and the date/time ports. the receiver cannot stall: the word is gone
//   after that cycle. set and rebase return only accepted, the rest reads zero.
//   configuration: apb port, earliest_year at 0x0, latest_year at 0x4; the user
//   writes them only while the clock is idle, which the block does not enforce.
// divider
//   every division runs through one shared radix-2 divider, one quotient bit per
//   cycle, so the divisions set the run time of an op; a set rejected on the window
//   or the time fields ends before any division, one rejected on the day after the
//   leap-year divisions by 400 and 100, and op 3 is answered straight from idle. one
//   word is in flight at a time; done and a new start may share a cycle.
// reset
//   base at 1980-01-01 00:00:00.00, base tick zero, year window 1980 to 2099.
`default_nettype none
`include "tick_calendar_clock_macros.svh"

module tick_calendar_clock #(
    parameter int unsigned TICK_HZ = tcc_pkg::TICK_HZ_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] now_tick,
    input  wire logic [15:0] set_year,
    input  wire logic [3:0]  set_month,
    input  wire logic [4:0]  set_day,
    input  wire logic [4:0]  set_hour,
    input  wire logic [5:0]  set_minute,
    input  wire logic [5:0]  set_second,
    input  wire logic [6:0]  set_hundredth,
    // result
    output logic             done,
    output logic             accepted,
    output logic [15:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day,
    output logic [2:0]       weekday,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [6:0]       hundredth,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tcc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        // set sequence
        S_CHK, S_M400, S_M100, S_DAYCHK, S_ERA, S_DOY, S_Y100, S_DAYS, S_MUL,
        S_ADD_H, S_ADD_M, S_ADD_S,
        // read and rebase sequence
        R_DELTA, R_DHZ, R_MULA, R_MULB, R_DFRAC, R_BASE, R_DDAY, R_DWD, R_DERA,
        R_D1460, R_D36524, R_D146096, R_D365, R_DY100, R_DMP, R_DD, R_DH, R_DMI,
        R_DS
    } state_t;

    localparam logic [DIV_W-1:0] HZ_DIV = DIV_W'(TICK_HZ);

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // result word
    logic        accepted_reg, accepted_next;
    logic [15:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [2:0]  weekday_reg, weekday_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [6:0]  hundredth_reg, hundredth_next;

    // command word held for the whole operation
    logic [1:0]  op_reg, op_next;
    logic [63:0] now_reg, now_next;
    logic [15:0] yr_reg, yr_next;
    logic [3:0]  mo_reg, mo_next;
    logic [4:0]  dy_reg, dy_next;
    logic [4:0]  hh_reg, hh_next;
    logic [5:0]  mi_reg, mi_next;
    logic [5:0]  ss_reg, ss_next;
    logic [6:0]  cs_reg, cs_next;

    // configuration and clock state
    logic [13:0] earliest_reg, earliest_next;
    logic [13:0] latest_reg, latest_next;
    logic [63:0] base_cs_reg, base_cs_next;
    logic [63:0] base_tick_reg, base_tick_next;

    // working registers
    logic [63:0] acc_reg, acc_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] q_reg, q_next;
    logic [23:0] rest_reg, rest_next;
    logic [15:0] era_reg, era_next;
    logic [17:0] doe_reg, doe_next;
    logic [17:0] w_reg, w_next;
    logic [8:0]  yoe_reg, yoe_next;
    logic [8:0]  doy_reg, doy_next;
    logic [3:0]  mp_reg, mp_next;
    logic        r400z_reg, r400z_next;
    logic        r100z_reg, r100z_next;

    // serial divider
    logic             dv_active_reg, dv_active_next;
    logic [CNT_W-1:0] dv_cnt_reg, dv_cnt_next;
    logic [63:0]      dv_num_reg, dv_num_next;
    logic [DIV_W-1:0] dv_rem_reg, dv_rem_next;

    logic             is_div;
    logic [63:0]      dv_num_in;
    logic [DIV_W-1:0] dv_den;
    logic [CNT_W-1:0] dv_len;
    logic [DIV_W:0]   dv_trial;
    logic [DIV_W:0]   dv_sub;
    logic             dv_ge;
    logic             dv_fin;
    logic [63:0]      dq;
    logic [DIV_W-1:0] dr;

    logic             cfg_wr;
    logic             leap;
    logic [4:0]       mlen;
    logic [3:0]       mp_set;
    logic [3:0]       mo_out;
    logic signed [31:0] set_days;
    logic signed [55:0] set_prod;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign accepted  = accepted_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;
    assign weekday   = weekday_reg;
    assign hour      = hour_reg;
    assign minute    = minute_reg;
    assign second    = second_reg;
    assign hundredth = hundredth_reg;

    // apb: registers decoded on the word address bit
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {18'd0, latest_reg} : {18'd0, earliest_reg};
    assign cfg_wr = psel & penable & pwrite & pready;

    // divider operands for each dividing step
    always_comb
    begin
        is_div    = 1'b1;
        dv_num_in = '0;
        dv_den    = '0;
        dv_len    = '0;
        unique case (state_reg)
            S_M400:
            begin
                dv_num_in = {48'd0, yr_reg};
                dv_den    = DIV_W'(400);
                dv_len    = CNT_W'(16);
            end
            S_M100:
            begin
                dv_num_in = {48'd0, yr_reg};
                dv_den    = DIV_W'(100);
                dv_len    = CNT_W'(16);
            end
            S_ERA:
            begin
                dv_num_in = {48'd0, yr_reg - {15'd0, (mo_reg <= 4'd2)}};
                dv_den    = DIV_W'(400);
                dv_len    = CNT_W'(16);
            end
            S_DOY:
            begin
                dv_num_in = {53'd0, 11'(mp_set * 8'd153) + 11'd2};
                dv_den    = DIV_W'(5);
                dv_len    = CNT_W'(11);
            end
            S_Y100, R_DY100:
            begin
                dv_num_in = {55'd0, yoe_reg};
                dv_den    = DIV_W'(100);
                dv_len    = CNT_W'(9);
            end
            R_DHZ:
            begin
                dv_num_in = tmp_reg;
                dv_den    = HZ_DIV;
                dv_len    = CNT_W'(64);
            end
            R_DFRAC:
            begin
                dv_num_in = tmp_reg;
                dv_den    = HZ_DIV;
                dv_len    = CNT_W'(37);
            end
            R_DDAY:
            begin
                dv_num_in = acc_reg;
                dv_den    = DIV_W'(CS_PER_DAY);
                dv_len    = CNT_W'(64);
            end
            R_DWD:
            begin
                dv_num_in = tmp_reg + 64'd4;
                dv_den    = DIV_W'(7);
                dv_len    = CNT_W'(42);
            end
            R_DERA:
            begin
                dv_num_in = tmp_reg;
                dv_den    = DIV_W'(ERA_DAYS);
                dv_len    = CNT_W'(42);
            end
            R_D1460:
            begin
                dv_num_in = {46'd0, doe_reg};
                dv_den    = DIV_W'(1460);
                dv_len    = CNT_W'(18);
            end
            R_D36524:
            begin
                dv_num_in = {46'd0, doe_reg};
                dv_den    = DIV_W'(36524);
                dv_len    = CNT_W'(18);
            end
            R_D146096:
            begin
                dv_num_in = {46'd0, doe_reg};
                dv_den    = DIV_W'(146096);
                dv_len    = CNT_W'(18);
            end
            R_D365:
            begin
                dv_num_in = {46'd0, w_reg};
                dv_den    = DIV_W'(365);
                dv_len    = CNT_W'(18);
            end
            R_DMP:
            begin
                dv_num_in = {53'd0, 11'(doy_reg * 3'd5) + 11'd2};
                dv_den    = DIV_W'(153);
                dv_len    = CNT_W'(11);
            end
            R_DD:
            begin
                dv_num_in = {53'd0, 11'(mp_reg * 8'd153) + 11'd2};
                dv_den    = DIV_W'(5);
                dv_len    = CNT_W'(11);
            end
            R_DH:
            begin
                dv_num_in = {40'd0, rest_reg};
                dv_den    = DIV_W'(CS_PER_HOUR);
                dv_len    = CNT_W'(24);
            end
            R_DMI:
            begin
                dv_num_in = {40'd0, rest_reg};
                dv_den    = DIV_W'(CS_PER_MIN);
                dv_len    = CNT_W'(19);
            end
            R_DS:
            begin
                dv_num_in = {40'd0, rest_reg};
                dv_den    = DIV_W'(CS_PER_SEC);
                dv_len    = CNT_W'(13);
            end
            default:
            begin
                is_div = 1'b0;
            end
        endcase
    end

    // one quotient bit per cycle
    assign dv_trial = {dv_rem_reg, dv_num_reg[63]};
    assign dv_sub   = dv_trial - {1'b0, dv_den};
    assign dv_ge    = (dv_trial >= {1'b0, dv_den});
    assign dv_fin   = is_div & dv_active_reg & (dv_cnt_reg == '0);
    assign dq       = dv_num_reg;
    assign dr       = dv_rem_reg;

    // calendar helpers
    assign leap   = ((yr_reg[1:0] == 2'd0) && !r100z_reg) || r400z_reg;
    assign mlen   = ((mo_reg == 4'd2) && leap) ? 5'd29 : MONTH_DAYS[mo_reg - 4'd1];
    assign mp_set = (mo_reg > 4'd2) ? mo_reg - 4'd3 : mo_reg + 4'd9;
    assign mo_out = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;
    assign set_days = $signed({{16{era_reg[15]}}, era_reg}) * 32'sd146097
                    + $signed({14'd0, doe_reg}) - $signed(32'(SET_OFFSET));
    assign set_prod = $signed(tmp_reg[31:0]) * $signed(25'(CS_PER_DAY));

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        accepted_next  = accepted_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        weekday_next   = weekday_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        hundredth_next = hundredth_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        yr_next        = yr_reg;
        mo_next        = mo_reg;
        dy_next        = dy_reg;
        hh_next        = hh_reg;
        mi_next        = mi_reg;
        ss_next        = ss_reg;
        cs_next        = cs_reg;
        earliest_next  = earliest_reg;
        latest_next    = latest_reg;
        base_cs_next   = base_cs_reg;
        base_tick_next = base_tick_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        q_next         = q_reg;
        rest_next      = rest_reg;
        era_next       = era_reg;
        doe_next       = doe_reg;
        w_next         = w_reg;
        yoe_next       = yoe_reg;
        doy_next       = doy_reg;
        mp_next        = mp_reg;
        r400z_next     = r400z_reg;
        r100z_next     = r100z_reg;
        dv_active_next = dv_active_reg;
        dv_cnt_next    = dv_cnt_reg;
        dv_num_next    = dv_num_reg;
        dv_rem_next    = dv_rem_reg;

        if (cfg_wr)
        begin
            if (paddr[2])
                latest_next = pwdata[13:0];
            else
                earliest_next = pwdata[13:0];
        end

        // divider: shift, load, release
        if (dv_active_reg && (dv_cnt_reg != '0))
        begin
            dv_rem_next = dv_ge ? dv_sub[DIV_W-1:0] : dv_trial[DIV_W-1:0];
            dv_num_next = {dv_num_reg[62:0], dv_ge};
            dv_cnt_next = dv_cnt_reg - CNT_W'(1);
        end
        if (is_div && !dv_active_reg)
        begin
            dv_active_next = 1'b1;
            dv_cnt_next    = dv_len;
            dv_num_next    = dv_num_in << (CNT_W'(64) - dv_len);
            dv_rem_next    = '0;
        end
        if (dv_fin)
            dv_active_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = op;
                    now_next       = now_tick;
                    yr_next        = set_year;
                    mo_next        = set_month;
                    dy_next        = set_day;
                    hh_next        = set_hour;
                    mi_next        = set_minute;
                    ss_next        = set_second;
                    cs_next        = set_hundredth;
                    accepted_next  = 1'b0;
                    year_next      = '0;
                    month_next     = '0;
                    day_next       = '0;
                    weekday_next   = '0;
                    hour_next      = '0;
                    minute_next    = '0;
                    second_next    = '0;
                    hundredth_next = '0;
                    unique case (op) inside
                        OP_SET:
                            state_next = S_CHK;
                        OP_READ, OP_REBASE:
                            state_next = R_DELTA;
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end

            // ---------------- set ----------------
            S_CHK:
            begin
                if ((yr_reg < {2'd0, earliest_reg}) || (yr_reg > {2'd0, latest_reg}) ||
                    (mo_reg < 4'd1) || (mo_reg > 4'd12) || (hh_reg > 5'd23) ||
                    (mi_reg > 6'd59) || (ss_reg > 6'd59) || (cs_reg > 7'd99))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = S_M400;
                end
            end
            S_M400:
            begin
                if (dv_fin)
                begin
                    r400z_next = (dr == '0);
                    state_next = S_M100;
                end
            end
            S_M100:
            begin
                if (dv_fin)
                begin
                    r100z_next = (dr == '0);
                    state_next = S_DAYCHK;
                end
            end
            S_DAYCHK:
            begin
                if ((dy_reg == 5'd0) || (dy_reg > mlen))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if ((yr_reg == 16'd0) && (mo_reg <= 4'd2))
                begin
                    // year before zero: era minus one, last year of that era
                    era_next   = '1;
                    yoe_next   = 9'd399;
                    state_next = S_DOY;
                end
                else
                begin
                    state_next = S_ERA;
                end
            end
            S_ERA:
            begin
                if (dv_fin)
                begin
                    era_next   = dq[15:0];
                    yoe_next   = dr[8:0];
                    state_next = S_DOY;
                end
            end
            S_DOY:
            begin
                if (dv_fin)
                begin
                    doy_next   = 9'(dq[8:0] + {4'd0, dy_reg} - 9'd1);
                    state_next = S_Y100;
                end
            end
            S_Y100:
            begin
                if (dv_fin)
                begin
                    doe_next   = 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2])
                               - 18'(dq[8:0]) + 18'(doy_reg);
                    state_next = S_DAYS;
                end
            end
            S_DAYS:
            begin
                tmp_next   = {32'd0, set_days};
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next   = {{8{set_prod[55]}}, set_prod};
                state_next = S_ADD_H;
            end
            S_ADD_H:
            begin
                acc_next   = acc_reg + {40'd0, 24'(hh_reg * 19'(CS_PER_HOUR))};
                state_next = S_ADD_M;
            end
            S_ADD_M:
            begin
                acc_next   = acc_reg + {40'd0, 24'(mi_reg * 13'(CS_PER_MIN))};
                state_next = S_ADD_S;
            end
            S_ADD_S:
            begin
                base_cs_next   = acc_reg + {51'd0, 13'(ss_reg * 7'(CS_PER_SEC))}
                               + {57'd0, cs_reg};
                base_tick_next = now_reg;
                accepted_next  = 1'b1;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            // ---------------- read and rebase ----------------
            R_DELTA:
            begin
                tmp_next   = (now_reg >= base_tick_reg) ? now_reg - base_tick_reg : '0;
                state_next = R_DHZ;
            end
            R_DHZ:
            begin
                if (dv_fin)
                begin
                    q_next     = dq;
                    // leftover ticks scaled to centiseconds, below 2^37
                    tmp_next   = {27'd0, 37'(dr * 7'd100)};
                    state_next = R_MULA;
                end
            end
            R_MULA:
            begin
                acc_next   = {q_reg[57:0], 6'd0} + {q_reg[58:0], 5'd0};
                state_next = R_MULB;
            end
            R_MULB:
            begin
                acc_next   = acc_reg + {q_reg[61:0], 2'd0};
                state_next = R_DFRAC;
            end
            R_DFRAC:
            begin
                if (dv_fin)
                begin
                    acc_next   = acc_reg + dq;
                    state_next = R_BASE;
                end
            end
            R_BASE:
            begin
                if (op_reg == OP_REBASE)
                begin
                    base_cs_next   = base_cs_reg + acc_reg;
                    base_tick_next = '0;
                    accepted_next  = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    acc_next   = base_cs_reg + acc_reg;
                    state_next = R_DDAY;
                end
            end
            R_DDAY:
            begin
                if (dv_fin)
                begin
                    tmp_next   = dq + 64'(EPOCH_DAYS);
                    rest_next  = dr[23:0];
                    state_next = R_DWD;
                end
            end
            R_DWD:
            begin
                if (dv_fin)
                begin
                    weekday_next = dr[2:0];
                    tmp_next     = tmp_reg + 64'(SHIFT_DAYS);
                    state_next   = R_DERA;
                end
            end
            R_DERA:
            begin
                if (dv_fin)
                begin
                    era_next   = dq[15:0];
                    doe_next   = dr[17:0];
                    state_next = R_D1460;
                end
            end
            R_D1460:
            begin
                if (dv_fin)
                begin
                    w_next     = doe_reg - dq[17:0];
                    state_next = R_D36524;
                end
            end
            R_D36524:
            begin
                if (dv_fin)
                begin
                    w_next     = w_reg + dq[17:0];
                    state_next = R_D146096;
                end
            end
            R_D146096:
            begin
                if (dv_fin)
                begin
                    w_next     = w_reg - dq[17:0];
                    state_next = R_D365;
                end
            end
            R_D365:
            begin
                if (dv_fin)
                begin
                    yoe_next   = dq[8:0];
                    state_next = R_DY100;
                end
            end
            R_DY100:
            begin
                if (dv_fin)
                begin
                    doy_next   = 9'(doe_reg - (18'(yoe_reg) * 18'd365
                               + 18'(yoe_reg[8:2]) - 18'(dq[8:0])));
                    state_next = R_DMP;
                end
            end
            R_DMP:
            begin
                if (dv_fin)
                begin
                    mp_next    = dq[3:0];
                    state_next = R_DD;
                end
            end
            R_DD:
            begin
                if (dv_fin)
                begin
                    day_next   = 5'(doy_reg - dq[8:0] + 9'd1);
                    month_next = mo_out;
                    year_next  = 16'(yoe_reg) + era_reg * 16'd400
                               + {15'd0, (mo_out <= 4'd2)};
                    state_next = R_DH;
                end
            end
            R_DH:
            begin
                if (dv_fin)
                begin
                    hour_next  = dq[4:0];
                    rest_next  = dr[23:0];
                    state_next = R_DMI;
                end
            end
            R_DMI:
            begin
                if (dv_fin)
                begin
                    minute_next = dq[5:0];
                    rest_next   = dr[23:0];
                    state_next  = R_DS;
                end
            end
            R_DS:
            begin
                if (dv_fin)
                begin
                    second_next    = dq[5:0];
                    hundredth_next = dr[6:0];
                    accepted_next  = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, result word and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            dv_active_reg <= 1'b0;
            dv_cnt_reg    <= '0;
            earliest_reg  <= 14'd1980;
            latest_reg    <= 14'd2099;
            base_cs_reg   <= '0;
            base_tick_reg <= '0;
            accepted_reg  <= 1'b0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            weekday_reg   <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            hundredth_reg <= '0;
            op_reg        <= '0;
            now_reg       <= '0;
            yr_reg        <= '0;
            mo_reg        <= '0;
            dy_reg        <= '0;
            hh_reg        <= '0;
            mi_reg        <= '0;
            ss_reg        <= '0;
            cs_reg        <= '0;
            acc_reg       <= '0;
            tmp_reg       <= '0;
            q_reg         <= '0;
            rest_reg      <= '0;
            era_reg       <= '0;
            doe_reg       <= '0;
            w_reg         <= '0;
            yoe_reg       <= '0;
            doy_reg       <= '0;
            mp_reg        <= '0;
            r400z_reg     <= 1'b0;
            r100z_reg     <= 1'b0;
            dv_num_reg    <= '0;
            dv_rem_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            dv_active_reg <= dv_active_next;
            dv_cnt_reg    <= dv_cnt_next;
            earliest_reg  <= earliest_next;
            latest_reg    <= latest_next;
            base_cs_reg   <= base_cs_next;
            base_tick_reg <= base_tick_next;
            accepted_reg  <= accepted_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            weekday_reg   <= weekday_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            hundredth_reg <= hundredth_next;
            op_reg        <= op_next;
            now_reg       <= now_next;
            yr_reg        <= yr_next;
            mo_reg        <= mo_next;
            dy_reg        <= dy_next;
            hh_reg        <= hh_next;
            mi_reg        <= mi_next;
            ss_reg        <= ss_next;
            cs_reg        <= cs_next;
            acc_reg       <= acc_next;
            tmp_reg       <= tmp_next;
            q_reg         <= q_next;
            rest_reg      <= rest_next;
            era_reg       <= era_next;
            doe_reg       <= doe_next;
            w_reg         <= w_next;
            yoe_reg       <= yoe_next;
            doy_reg       <= doy_next;
            mp_reg        <= mp_next;
            r400z_reg     <= r400z_next;
            r100z_reg     <= r100z_next;
            dv_num_reg    <= dv_num_next;
            dv_rem_reg    <= dv_rem_next;
        end
    end

    // checks
    `TCC_ASSERT_IMPL(a_done_idle, done_reg, state_reg == ST_IDLE)
    `TCC_ASSERT_NEXT(a_start_moves, start && !busy, busy || done_reg)
    `TCC_ASSERT_IMPL(a_quiet_word, done_reg && op_reg != OP_READ, year_reg == '0 && hour_reg == '0)
    `TCC_ASSERT_IMPL(a_div_in_op, dv_active_reg, state_reg != ST_IDLE)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for tick_calendar_clock: directed and random command words
// checked against an in-bench calendar predictor; depends on tcc_pkg and the rtl only
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*;

    localparam int unsigned HZ = TICK_HZ_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // register byte addresses
    localparam logic [2:0] REG_EARLIEST = 3'd0;
    localparam logic [2:0] REG_LATEST   = 3'd4;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] tick;
        logic [15:0] yr;
        logic [3:0]  mon;
        logic [4:0]  dd;
        logic [4:0]  hh;
        logic [5:0]  mi;
        logic [5:0]  ss;
        logic [6:0]  cs;
    } cmd_word_t;

    typedef struct packed {
        logic        accepted;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [6:0]  hundredth;
    } clock_word_t;

    // clock, reset and every block input known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  op = '0;
    logic [63:0] now_tick = '0;
    logic [15:0] set_year = '0;
    logic [3:0]  set_month = '0;
    logic [4:0]  set_day = '0;
    logic [4:0]  set_hour = '0;
    logic [5:0]  set_minute = '0;
    logic [5:0]  set_second = '0;
    logic [6:0]  set_hundredth = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        busy, done, accepted, pready;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day, hour;
    logic [2:0]  weekday;
    logic [5:0]  minute, second;
    logic [6:0]  hundredth;
    logic [31:0] prdata;

    tick_calendar_clock dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state and register mirror
    logic [63:0] base_cs;
    logic [63:0] base_tick_at;
    logic [13:0] first_year;
    logic [13:0] last_year;

    cmd_word_t   cmd_queue[$];
    clock_word_t expected_words[$];
    int          mismatches = 0;

    // stimulus-side view of time
    logic [63:0] tick_cursor = '0;

    function automatic logic is_leap(logic [63:0] y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic logic [4:0] month_length(logic [63:0] y, logic [3:0] m);
        logic [4:0] lens [12];
        lens = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
        if (m == 4'd2 && is_leap(y))
            return 5'd29;
        return lens[m - 4'd1];
    endfunction

    // signed day number relative to 1970-01-01
    function automatic longint date_to_day_num(logic [15:0] y, logic [3:0] m, logic [4:0] d);
        longint      sy;
        longint      era;
        logic [63:0] yoe, mp, doy, doe;
        sy  = longint'({48'd0, y}) - ((m <= 2) ? 1 : 0);
        era = (sy >= 0 ? sy : sy - 399) / 400;
        yoe = sy - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + longint'(doe) - 719468;
    endfunction

    // hundredths elapsed since the base tick, fraction kept apart
    function automatic logic [63:0] elapsed_hundredths(logic [63:0] now);
        logic [63:0] delta;
        delta = (now >= base_tick_at) ? now - base_tick_at : 64'd0;
        return (delta / HZ) * 100 + ((delta % HZ) * 100) / HZ;
    endfunction

    // apply one command word to the predictor, return the word the block should send
    function automatic clock_word_t apply_cmd(cmd_word_t c);
        clock_word_t r;
        logic [63:0] total, rest, abs_day, z, era, doe, yoe, doy, mp, m, y;
        r = '0;
        case (c.op)
            OP_SET:
            begin
                if (c.yr >= first_year && c.yr <= last_year && c.mon >= 1 && c.mon <= 12
                    && c.dd >= 1 && c.dd <= month_length(c.yr, c.mon) && c.hh <= 23
                    && c.mi <= 59 && c.ss <= 59 && c.cs <= 99)
                begin
                    base_cs = 64'(date_to_day_num(c.yr, c.mon, c.dd) - 3652) * 64'd8640000
                            + c.hh * 64'd360000 + c.mi * 64'd6000 + c.ss * 64'd100 + c.cs;
                    base_tick_at = c.tick;
                    r.accepted = 1'b1;
                end
            end
            OP_READ:
            begin
                total   = base_cs + elapsed_hundredths(c.tick);
                rest    = total % 8640000;
                abs_day = total / 8640000 + 3652;
                z   = abs_day + 719468;
                era = z / 146097;
                doe = z - era * 146097;
                yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
                mp  = (5 * doy + 2) / 153;
                m   = (mp < 10) ? mp + 3 : mp - 9;
                y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
                r.accepted  = 1'b1;
                r.year      = y[15:0];
                r.month     = m[3:0];
                r.day       = 5'(doy - (153 * mp + 2) / 5 + 1);
                r.weekday   = 3'((abs_day + 4) % 7);
                r.hour      = 5'(rest / 360000);
                rest        = rest % 360000;
                r.minute    = 6'(rest / 6000);
                rest        = rest % 6000;
                r.second    = 6'(rest / 100);
                r.hundredth = 7'(rest % 100);
            end
            OP_REBASE:
            begin
                base_cs      = base_cs + elapsed_hundredths(c.tick);
                base_tick_at = '0;
                r.accepted   = 1'b1;
            end
            default:
            begin
                // unused op: no state change, all-zero word
            end
        endcase
        return r;
    endfunction

    // driver: bursts of back-to-back words with random gaps in between
    int burst_left = 1;
    int gap_left = 0;
    cmd_word_t on_bus;

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic fire;
        if (!rst_n)
        begin
            start <= 1'b0;
            base_cs = '0;
            base_tick_at = '0;
        end
        else
        begin
            fire = start && !busy;
            if (fire)
                expected_words.push_back(apply_cmd(on_bus));
            // bus is free for a new word only when idle or the current one was taken
            if (!start || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    on_bus = cmd_queue.pop_front();
                    op            <= on_bus.op;
                    now_tick      <= on_bus.tick;
                    set_year      <= on_bus.yr;
                    set_month     <= on_bus.mon;
                    set_day       <= on_bus.dd;
                    set_hour      <= on_bus.hh;
                    set_minute    <= on_bus.mi;
                    set_second    <= on_bus.ss;
                    set_hundredth <= on_bus.cs;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        // roughly a third of bursts run with no gap at all
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: the block cannot be stalled, every done cycle is a word
    always @(posedge clk)
    begin : monitor
        clock_word_t got, want;
        if (rst_n && done)
        begin
            got = '{accepted, year, month, day, weekday, hour, minute, second, hundredth};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", got);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.accepted !== want.accepted || got.year !== want.year
                    || got.month !== want.month || got.day !== want.day
                    || got.weekday !== want.weekday || got.hour !== want.hour
                    || got.minute !== want.minute || got.second !== want.second
                    || got.hundredth !== want.hundredth)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [13:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {18'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_EARLIEST)
            first_year = value;
        else
            last_year = value;
    endtask

    // block until every queued word is taken and every result has come back;
    // checked on the falling edge so the driver's updates have settled
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_queue.size() > 0 || start || expected_words.size() > 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic cmd_word_t make_cmd(logic [1:0] o, logic [63:0] t, int y, int m,
                                           int d, int h, int mi, int s, int cs);
        cmd_word_t c;
        c = '{o, t, y[15:0], m[3:0], d[4:0], h[4:0], mi[5:0], s[5:0], cs[6:0]};
        return c;
    endfunction

    // advance the stimulus tick; mostly forward by realistic amounts
    function automatic logic [63:0] next_tick();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            tick_cursor += $urandom_range(0, HZ * 200);
        else if (pick < 80)
            tick_cursor += $urandom;
        else if (pick < 90)
            tick_cursor += {$urandom, $urandom} >> $urandom_range(8, 40);
        else if (pick < 95)
            return {$urandom, $urandom};
        else
            return tick_cursor - $urandom_range(1, 1000); // behind the tick cursor
        return tick_cursor;
    endfunction

    function automatic cmd_word_t random_cmd();
        cmd_word_t   c;
        int unsigned pick;
        int          y, m;
        pick = $urandom_range(0, 99);
        if (pick < 38)
        begin
            // well-formed set inside the current year window
            y = $urandom_range(first_year, last_year);
            m = $urandom_range(1, 12);
            c = make_cmd(OP_SET, next_tick(), y, m, $urandom_range(1, month_length(y, m)),
                         $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                         $urandom_range(0, 99));
        end
        else if (pick < 53)
        begin
            // noise: every set field over its full width
            c = make_cmd(OP_SET, next_tick(), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        end
        else if (pick < 85)
            c = make_cmd(OP_READ, next_tick(), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        else if (pick < 96)
            c = make_cmd(OP_REBASE, next_tick(), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        else
            c = make_cmd(OP_UNUSED, {$urandom, $urandom}, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
        return c;
    endfunction

    initial
    begin : stimulus
        logic [13:0] windows [5][2];
        logic [63:0] t;
        first_year = 14'd1980;
        last_year  = 14'd2099;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // register reset values first, so the directed part runs in the default window
        t = 64'd5000;
        cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 1980, 1, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_READ, t, 0, 0, 0, 0, 0, 0, 0));
        // tick before base gives zero elapsed
        cmd_queue.push_back(make_cmd(OP_READ, 64'd4999, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2099, 12, 31, 23, 59, 59, 99));
        cmd_queue.push_back(make_cmd(OP_READ, t + HZ + 7, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2000, 2, 29, 12, 30, 30, 50));
        cmd_queue.push_back(make_cmd(OP_READ, t + 64'(HZ) * 86400, 0, 0, 0, 0, 0, 0, 0));
        // rejected sets: year window, bad month, day, hour, minute, second, hundredth
        cmd_queue.push_back(make_cmd(OP_SET, t, 2100, 1, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 1979, 12, 31, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2023, 2, 29, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 2, 30, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 0, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 13, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 4, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 4, 31, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 4, 1, 24, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 4, 1, 0, 60, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 4, 1, 0, 0, 60, 0));
        cmd_queue.push_back(make_cmd(OP_SET, t, 2024, 4, 1, 0, 0, 0, 100));
        cmd_queue.push_back(make_cmd(OP_READ, '1, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_REBASE, '1, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_READ, 64'd100, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_UNUSED, '1, 16'hffff, 15, 31, 31, 63, 63, 127));
        // sender waits for every result here
        drain();

        // year windows, extremes included; the last one restores the reset window
        windows = '{'{14'd0, 14'h3fff}, '{14'd1980, 14'd9999}, '{14'd0, 14'd1979},
                    '{14'h3fff, 14'h3fff}, '{14'd1980, 14'd2099}};
        for (int p = 0; p < 5; p++)
        begin
            reg_write(REG_EARLIEST, windows[p][0]);
            reg_write(REG_LATEST, windows[p][1]);
            for (int i = 0; i < 135; i++)
                cmd_queue.push_back(random_cmd());
            drain();
        end

        repeat (600) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #80ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/tcc_pkg.sv
sv/tick_calendar_clock.sv
verif/tb.sv
